### src/cchd_pkg.sv
// Shared types and constants for the coastline cliff height delta pipeline.
package cchd_pkg;

  localparam int HEIGHT_W = 24;
  localparam int COORD_W  = 24;
  localparam int THRESH_W = 23;
  localparam int GLIM_W   = 49;
  localparam int INDEX_W  = 28;
  localparam int DIST_W   = THRESH_W;
  localparam int VALUE_W  = HEIGHT_W + 1;
  localparam int UBITS    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GLIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SEA_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAND_LIFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEA_CUT      = 3'd4;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] sea_level;
    logic        [THRESH_W-1:0] band_threshold;
    logic        [GLIM_W-1:0]   gradient_limit_sq;
    logic signed [HEIGHT_W-1:0] land_lift;
    logic signed [HEIGHT_W-1:0] sea_cut;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  cell_z;
    logic signed [COORD_W-1:0]  cell_x;
    logic signed [HEIGHT_W-1:0] up_height;
    logic signed [HEIGHT_W-1:0] down_height;
    logic signed [HEIGHT_W-1:0] right_height;
    logic signed [HEIGHT_W-1:0] left_height;
    logic signed [HEIGHT_W-1:0] center_height;
  } sample_t;

  // Per-cell state carried alongside the division.
  typedef struct packed {
    logic                       keep;
    logic                       umax;
    logic signed [VALUE_W-1:0]  value;
    logic signed [COORD_W-1:0]  cell_x;
    logic signed [COORD_W-1:0]  cell_z;
  } item_t;

endpackage

### src/cchd_front.sv
// Front stages: band test, distance to sea level and squared gradient test.
module cchd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  cchd_pkg::sample_t              in_data,
  input  cchd_pkg::cfg_t                 cfg,
  output logic                           out_valid,
  output cchd_pkg::item_t                out_item,
  output logic [cchd_pkg::DIST_W-1:0]    out_dist
);
  import cchd_pkg::*;

  // Stage 1 registers.
  logic                       v1;
  logic signed [VALUE_W-1:0]  diff1;
  logic signed [VALUE_W-1:0]  gx1;
  logic signed [VALUE_W-1:0]  gz1;
  logic signed [COORD_W-1:0]  cx1;
  logic signed [COORD_W-1:0]  cz1;

  // Stage 2 registers.
  logic                       v2;
  logic                       inband2;
  logic                       umax2;
  logic [DIST_W-1:0]          dist2;
  logic signed [VALUE_W-1:0]  value2;
  logic [2*HEIGHT_W-1:0]      gxsq2;
  logic [2*HEIGHT_W-1:0]      gzsq2;
  logic signed [COORD_W-1:0]  cx2;
  logic signed [COORD_W-1:0]  cz2;

  // Stage 3 registers.
  logic                       v3;
  item_t                      item3;
  logic [DIST_W-1:0]          dist3;

  logic [VALUE_W-1:0]         mag;
  logic                       inband;
  logic signed [2*VALUE_W-1:0] gxsq_full;
  logic signed [2*VALUE_W-1:0] gzsq_full;
  logic [GLIM_W-1:0]          gsum;

  always_comb begin
    mag = diff1[VALUE_W-1] ? VALUE_W'(-diff1) : diff1;
    inband = (cfg.band_threshold != '0) &&
             (mag <= {2'b00, cfg.band_threshold});
    gxsq_full = gx1 * gx1;
    gzsq_full = gz1 * gz1;
    gsum = {1'b0, gxsq2} + {1'b0, gzsq2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff1 <= VALUE_W'(in_data.center_height) - VALUE_W'(cfg.sea_level);
      gx1   <= VALUE_W'(in_data.right_height) - VALUE_W'(in_data.left_height);
      gz1   <= VALUE_W'(in_data.up_height) - VALUE_W'(in_data.down_height);
      cx1   <= in_data.cell_x;
      cz1   <= in_data.cell_z;

      inband2 <= inband;
      umax2   <= (mag == {2'b00, cfg.band_threshold});
      dist2   <= mag[DIST_W-1:0];
      // Exactly at sea level counts as the sea side.
      value2  <= (diff1 > 0) ? VALUE_W'(cfg.land_lift) : -VALUE_W'(cfg.sea_cut);
      gxsq2   <= gxsq_full[2*HEIGHT_W-1:0];
      gzsq2   <= gzsq_full[2*HEIGHT_W-1:0];
      cx2     <= cx1;
      cz2     <= cz1;

      item3.keep   <= inband2 && (gsum >= cfg.gradient_limit_sq);
      item3.umax   <= umax2;
      item3.value  <= value2;
      item3.cell_x <= cx2;
      item3.cell_z <= cz2;
      dist3        <= dist2;
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;
  assign out_dist  = dist3;

endmodule

### src/cchd_div.sv
// Pipelined restoring divider: one quotient bit of distance / threshold per stage.
module cchd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  cchd_pkg::item_t               in_item,
  input  logic [cchd_pkg::DIST_W-1:0]   in_dist,
  input  logic [cchd_pkg::THRESH_W-1:0] divisor,
  output logic                          out_valid,
  output cchd_pkg::item_t               out_item,
  output logic [cchd_pkg::UBITS-1:0]    out_quo
);
  import cchd_pkg::*;

  logic [UBITS-1:0]  v_q;
  item_t             item_q [UBITS];
  logic [DIST_W-1:0] rem_q  [UBITS];
  logic [UBITS-1:0]  quo_q  [UBITS];

  logic              v_in    [UBITS];
  item_t             item_in [UBITS];
  logic [DIST_W-1:0] rem_in  [UBITS];
  logic [UBITS-1:0]  quo_in  [UBITS];

  for (genvar k = 0; k < UBITS; k++) begin : g_stage
    logic [DIST_W:0] shifted;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in[k]    = in_valid;
      assign item_in[k] = in_item;
      assign rem_in[k]  = in_dist;
      assign quo_in[k]  = '0;
    end else begin : g_rest
      assign v_in[k]    = v_q[k-1];
      assign item_in[k] = item_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
    end

    assign shifted = {rem_in[k], 1'b0};
    assign ge      = shifted >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item_q[k] <= item_in[k];
        rem_q[k]  <= ge ? DIST_W'(shifted - {1'b0, divisor}) : shifted[DIST_W-1:0];
        quo_q[k]  <= {quo_in[k][UBITS-2:0], ge};
      end
    end
  end

  assign out_valid = v_q[UBITS-1];
  assign out_item  = item_q[UBITS-1];
  assign out_quo   = quo_q[UBITS-1];

endmodule

### src/cchd_blend.sv
// Smoothstep weight, scaling of the lift or cut, rounding and saturation.
module cchd_blend (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  cchd_pkg::item_t                    in_item,
  input  logic [cchd_pkg::UBITS-1:0]         in_quo,
  output logic                               out_valid,
  output logic signed [cchd_pkg::HEIGHT_W-1:0] out_delta
);
  import cchd_pkg::*;

  localparam int U_W    = UBITS + 1;
  localparam int UU_W   = 2 * UBITS + 1;
  localparam int M_W    = UBITS + 2;
  localparam int SP_W   = UU_W + M_W;
  localparam int PROD_W = VALUE_W + U_W + 1;
  localparam int R_W    = PROD_W - UBITS;
  localparam logic [U_W-1:0]      ONE      = U_W'(1) << UBITS;
  localparam logic [M_W-1:0]      THREE    = M_W'(3) << UBITS;
  localparam logic [PROD_W-1:0]   HALF     = PROD_W'(1) << (UBITS - 1);
  localparam logic [R_W-1:0]      POS_MAX  = R_W'((1 << (HEIGHT_W - 1)) - 1);
  localparam logic [R_W-1:0]      NEG_MAX  = R_W'(1 << (HEIGHT_W - 1));

  logic                        v1, v2, v3, v4;
  logic                        keep1, keep2, keep3, keep4;
  logic signed [VALUE_W-1:0]   value1, value2;
  logic [UU_W-1:0]             uu1;
  logic [M_W-1:0]              m1;
  logic [U_W-1:0]              s2;
  logic signed [PROD_W-1:0]    prod3;
  logic signed [HEIGHT_W-1:0]  delta4;

  logic [U_W-1:0]              u;
  logic [SP_W-1:0]             sprod;
  logic [U_W-1:0]              w;
  logic [PROD_W-1:0]           mag;
  logic [R_W-1:0]              r;
  logic [HEIGHT_W-1:0]         rs;
  logic signed [HEIGHT_W-1:0]  delta;

  always_comb begin
    u     = in_item.umax ? ONE : {1'b0, in_quo};
    sprod = uu1 * m1;
    w     = ONE - s2;
    mag   = prod3[PROD_W-1] ? PROD_W'(-prod3) : prod3;
    r     = R_W'((mag + HALF) >> UBITS);
    if (!prod3[PROD_W-1] && (r > POS_MAX)) begin
      rs = POS_MAX[HEIGHT_W-1:0];
    end else if (prod3[PROD_W-1] && (r > NEG_MAX)) begin
      rs = NEG_MAX[HEIGHT_W-1:0];
    end else begin
      rs = r[HEIGHT_W-1:0];
    end
    delta = prod3[PROD_W-1] ? -$signed(rs) : $signed(rs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      keep1  <= in_item.keep;
      value1 <= in_item.value;
      uu1    <= UU_W'(u * u);
      m1     <= THREE - M_W'({u, 1'b0});

      keep2  <= keep1;
      value2 <= value1;
      s2     <= U_W'(sprod >> (2 * UBITS));

      keep3  <= keep2;
      prod3  <= PROD_W'(value2) * $signed({1'b0, w});

      // A zero weight also rounds to a zero delta, which is dropped here.
      keep4  <= keep3 && (delta != '0);
      delta4 <= delta;
    end
  end

  assign out_valid = v4 && keep4;
  assign out_delta = delta4;

endmodule

### src/cchd_chunk.sv
// Chunk coordinates and index within the chunk, by reciprocal multiplication.
module cchd_chunk #(
  parameter int CHUNK_RES = 65
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [cchd_pkg::COORD_W-1:0] cell_x,
  input  logic signed [cchd_pkg::COORD_W-1:0] cell_z,
  output logic signed [cchd_pkg::COORD_W-1:0] chunk_x,
  output logic signed [cchd_pkg::COORD_W-1:0] chunk_z,
  output logic signed [cchd_pkg::INDEX_W-1:0] local_index
);
  import cchd_pkg::*;

  localparam int SPAN    = CHUNK_RES - 1;
  localparam int SH_L    = $clog2(SPAN);
  localparam int SHIFT   = COORD_W + SH_L;
  localparam int RECIP_W = COORD_W + 2;
  localparam int PROD_W  = COORD_W + RECIP_W;
  localparam int K_W     = SH_L + 2;
  localparam int WIDE_W  = COORD_W + K_W;
  localparam int LOC_W   = SH_L + 1;
  // Rounded-up reciprocal of the span; exact quotient for every coordinate.
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + SPAN - 1) / SPAN;
  localparam logic [RECIP_W-1:0]  RECIP_C = RECIP_W'(RECIP);
  localparam logic signed [K_W-1:0] SPAN_S = K_W'(SPAN);
  localparam logic signed [K_W-1:0] RES_S  = K_W'(CHUNK_RES);

  // Lane 0 is x, lane 1 is z.
  logic [PROD_W-1:0]          prod1  [2];
  logic                       neg1   [2];
  logic signed [COORD_W-1:0]  c1     [2];
  logic signed [COORD_W-1:0]  c2     [2];
  logic signed [COORD_W-1:0]  ch2    [2];
  logic signed [COORD_W-1:0]  ch3    [2];
  logic signed [LOC_W-1:0]    loc3   [2];
  logic signed [COORD_W-1:0]  ch4    [2];
  logic signed [INDEX_W-1:0]  idx4;

  logic signed [COORD_W-1:0]  cin    [2];
  logic [COORD_W-1:0]         mag    [2];
  logic [COORD_W-1:0]         q      [2];
  logic signed [WIDE_W-1:0]   back   [2];
  logic signed [WIDE_W-1:0]   rem    [2];
  logic signed [INDEX_W-1:0]  idx;

  always_comb begin
    cin[0] = cell_x;
    cin[1] = cell_z;
    for (int i = 0; i < 2; i++) begin
      mag[i]  = cin[i][COORD_W-1] ? COORD_W'(-cin[i]) : cin[i];
      q[i]    = COORD_W'(prod1[i] >> SHIFT);
      back[i] = WIDE_W'(ch2[i]) * WIDE_W'(SPAN_S);
      rem[i]  = WIDE_W'(c2[i]) - back[i];
    end
    idx = INDEX_W'(loc3[1]) * INDEX_W'(RES_S) + INDEX_W'(loc3[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        prod1[i] <= PROD_W'(mag[i]) * PROD_W'(RECIP_C);
        neg1[i]  <= cin[i][COORD_W-1];
        c1[i]    <= cin[i];

        ch2[i]   <= neg1[i] ? -$signed(q[i]) : $signed(q[i]);
        c2[i]    <= c1[i];

        ch3[i]   <= ch2[i];
        loc3[i]  <= LOC_W'(rem[i]);

        ch4[i]   <= ch3[i];
      end
      idx4 <= idx;
    end
  end

  assign chunk_x     = ch4[0];
  assign chunk_z     = ch4[1];
  assign local_index = idx4;

endmodule

### src/coastline_cliff_height_delta.sv
// Top level of the coastline cliff height delta pipeline.
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_axis    in         center, left, right, down, up heights, cell_x, cell_z
//  m_axis    out        chunk_x, chunk_z, local_index, height_delta
//  cfg       in         register index and data, one write per cycle
//
// The pipeline takes one word per cycle while it is not stalled and returns a result
// after three front stages, sixteen divider stages (one quotient bit each, which
// sets the depth) and four stages of weighting and chunk maths.
// Cells that fall outside the band, are too flat or round to a zero delta
// pass through as bubbles and produce no output word.
// Reset is synchronous; it clears the valid bits and restores the register
// defaults. When the output word is held by the consumer the whole pipeline
// stalls in place, so nothing is lost or repeated.
module coastline_cliff_height_delta #(
  parameter int CHUNK_RES = 65
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // center_height, left_height, right_height, down_height, up_height,
  // cell_x, cell_z (24 bits each, from bit 0 up)
  input  logic [167:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // chunk_x [23:0], chunk_z [47:24], local_index [75:48],
  // height_delta [99:76], zero padding [103:100]
  output logic [103:0]  m_tdata,
  input  logic          cfg_wen,
  input  logic [cchd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cchd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cchd_pkg::*;

  cfg_t    cfg;
  sample_t sample;
  logic    en;

  logic                        front_valid;
  item_t                       front_item;
  logic [DIST_W-1:0]           front_dist;
  logic                        div_valid;
  item_t                       div_item;
  logic [UBITS-1:0]            div_quo;
  logic signed [HEIGHT_W-1:0]  height_delta;
  logic signed [COORD_W-1:0]   chunk_x;
  logic signed [COORD_W-1:0]   chunk_z;
  logic signed [INDEX_W-1:0]   local_index;

  // Configuration registers; writes to unknown indices are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sea_level         <= '0;
      cfg.band_threshold    <= THRESH_W'(256);
      cfg.gradient_limit_sq <= '0;
      cfg.land_lift         <= '0;
      cfg.sea_cut           <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_SEA_LEVEL:   cfg.sea_level         <= cfg_wdata[HEIGHT_W-1:0];
        CFG_BAND_THRESH: cfg.band_threshold    <= cfg_wdata[THRESH_W-1:0];
        CFG_GRAD_LIMIT:  cfg.gradient_limit_sq <= cfg_wdata[GLIM_W-1:0];
        CFG_LAND_LIFT:   cfg.land_lift         <= cfg_wdata[HEIGHT_W-1:0];
        CFG_SEA_CUT:     cfg.sea_cut           <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // The last stage doubles as the output register, so the pipeline moves
  // whenever that register is empty or is being taken this cycle.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign sample = s_tdata;

  cchd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (sample),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_item  (front_item),
    .out_dist  (front_dist)
  );

  cchd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_item   (front_item),
    .in_dist   (front_dist),
    .divisor   (cfg.band_threshold),
    .out_valid (div_valid),
    .out_item  (div_item),
    .out_quo   (div_quo)
  );

  cchd_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_item   (div_item),
    .in_quo    (div_quo),
    .out_valid (m_tvalid),
    .out_delta (height_delta)
  );

  // Runs alongside the weighting stages with the same depth.
  cchd_chunk #(
    .CHUNK_RES (CHUNK_RES)
  ) u_chunk (
    .clk         (clk),
    .en          (en),
    .cell_x      (div_item.cell_x),
    .cell_z      (div_item.cell_z),
    .chunk_x     (chunk_x),
    .chunk_z     (chunk_z),
    .local_index (local_index)
  );

  assign m_tdata = {4'b0000, height_delta, local_index, chunk_z, chunk_x};

endmodule

### dv/coastline_cliff_height_delta_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the coastline cliff height delta pipeline.
module coastline_cliff_height_delta_test;
  import cchd_pkg::*;

  localparam int CHUNK_RES   = 65;
  // The pipeline is 23 stages deep; this leaves some margin after the last word.
  localparam int DRAIN       = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST = CFG_SEA_CUT;
  // Squared gradient of a cell whose neighbours sit at opposite extremes on both axes.
  localparam longint GRAD_EDGE = 2 * ((64'sd1 << 24) - 1) * ((64'sd1 << 24) - 1);
  localparam longint HALF_RANGE = 64'sd1 << 23;

  // One output word, laid out exactly as m_tdata[99:0].
  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height_delta;
    logic signed [INDEX_W-1:0]  local_index;
    logic signed [COORD_W-1:0]  chunk_z;
    logic signed [COORD_W-1:0]  chunk_x;
  } cliff_out_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [167:0]          s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [103:0]          m_tdata;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SEA_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Our own copy of the register file, kept in step with every write we issue.
  cfg_t       regs;
  sample_t    cell_q[$];     // cells waiting to be offered on the input stream
  cliff_out_t delta_q[$];    // predicted output words, oldest first
  int         mismatches = 0;

  // Set from the stimulus process on a falling edge, read on rising edges.
  bit steady       = 1'b0;   // no random idling on either side while set
  bit hold_request = 1'b0;   // asks the receiver for one long hold-off
  bit hold_done    = 1'b0;
  int hold_left    = 0;

  coastline_cliff_height_delta #(.CHUNK_RES(CHUNK_RES)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Works out the word that one cell produces, if any. The weight is
  // 1 - smoothstep(u) in Q1.16, where u is the distance from sea level as a
  // fraction of the band half width; the delta is rounded half away from zero.
  function automatic bit cliff_delta(input sample_t c, input cfg_t r, output cliff_out_t o);
    longint h, hl, hr, hd, hu, cx, cz, sea, t, glim, lift, cut;
    longint gx, gz, gsum, gap, u, s, w, value, prod, mag, rnd, delta;
    longint span, chx, chz, lx, lz;
    bit     neg;
    o    = '0;
    h    = c.center_height;
    hl   = c.left_height;
    hr   = c.right_height;
    hd   = c.down_height;
    hu   = c.up_height;
    cx   = c.cell_x;
    cz   = c.cell_z;
    sea  = r.sea_level;
    t    = r.band_threshold;
    glim = r.gradient_limit_sq;
    lift = r.land_lift;
    cut  = r.sea_cut;
    if (t == 0) return 1'b0;
    if (h < sea - t || h > sea + t) return 1'b0;
    gx   = hr - hl;
    gz   = hu - hd;
    gsum = gx * gx + gz * gz;
    if (gsum < glim) return 1'b0;
    gap  = (h >= sea) ? h - sea : sea - h;
    u    = (gap << 16) / t;
    if (u > 65536) u = 65536;
    s    = (u * u * (3 * 65536 - 2 * u)) >>> 32;
    w    = 65536 - s;
    if (w == 0) return 1'b0;
    // A cell exactly at sea level counts as sea side.
    value = (h > sea) ? lift : -cut;
    prod  = value * w;
    neg   = prod < 0;
    mag   = neg ? -prod : prod;
    rnd   = (mag + 32768) >>> 16;
    if (!neg && rnd > 64'h7FFFFF) rnd = 64'h7FFFFF;
    if (neg && rnd > 64'h800000) rnd = 64'h800000;
    delta = neg ? -rnd : rnd;
    if (delta == 0) return 1'b0;
    span = CHUNK_RES - 1;
    chx  = cx / span;
    chz  = cz / span;
    lx   = cx - chx * span;
    lz   = cz - chz * span;
    o.chunk_x      = chx[COORD_W-1:0];
    o.chunk_z      = chz[COORD_W-1:0];
    o.local_index  = INDEX_W'(lz * CHUNK_RES + lx);
    o.height_delta = delta[HEIGHT_W-1:0];
    return 1'b1;
  endfunction

  // Input side: offers queued cells, idling now and then, and predicts each
  // word as it is accepted.
  always @(posedge clk) begin
    cliff_out_t want;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready && cliff_delta(sample_t'(s_tdata), regs, want))
        delta_q.push_back(want);
      if (!s_tvalid || s_tready) begin
        if (cell_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          s_tdata  <= cell_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side back-pressure: random stalls, plus one long hold-off so that
  // the pipeline fills and has to refuse input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Output checker: every accepted word must match the oldest prediction.
  always @(posedge clk) begin
    cliff_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[99:0];
      if (m_tdata[103:100] !== '0) note_mismatch("padding bits of output word not zero");
      if (delta_q.size() == 0) begin
        note_mismatch($sformatf("output word %h with nothing expected", m_tdata));
      end else begin
        want = delta_q.pop_front();
        if (got.chunk_x !== want.chunk_x)
          note_mismatch($sformatf("chunk_x %h, expected %h", got.chunk_x, want.chunk_x));
        if (got.chunk_z !== want.chunk_z)
          note_mismatch($sformatf("chunk_z %h, expected %h", got.chunk_z, want.chunk_z));
        if (got.local_index !== want.local_index)
          note_mismatch($sformatf("local_index %h, expected %h",
                                  got.local_index, want.local_index));
        if (got.height_delta !== want.height_delta)
          note_mismatch($sformatf("height_delta %h, expected %h",
                                  got.height_delta, want.height_delta));
      end
    end
  end

  // Uniform value in [-m, m].
  function automatic longint spread(input longint m);
    return longint'($urandom_range(32'(2 * m))) - m;
  endfunction

  function automatic longint pick_scale();
    case ($urandom_range(2))
      0:       return $urandom_range(16, 1);
      1:       return $urandom_range(4096, 17);
      default: return $urandom_range(23'h7FFFFF, 4097);
    endcase
  endfunction

  // Coordinates near zero on both sides, near chunk boundaries, at the ends
  // of the range, or anywhere at all.
  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(3))
      0:       return COORD_W'($urandom);
      1:       return COORD_W'(spread(300));
      2:       return COORD_W'(spread(1000) * (CHUNK_RES - 1) + spread(1));
      default: return $urandom_range(1) ? COORD_W'(24'h7FFFFF - $urandom_range(70))
                                        : COORD_W'(24'h800000 + $urandom_range(70));
    endcase
  endfunction

  function automatic sample_t make_cell(input longint h, l, r, d, u, x, z);
    sample_t c;
    c.center_height = HEIGHT_W'(h);
    c.left_height   = HEIGHT_W'(l);
    c.right_height  = HEIGHT_W'(r);
    c.down_height   = HEIGHT_W'(d);
    c.up_height     = HEIGHT_W'(u);
    c.cell_x        = COORD_W'(x);
    c.cell_z        = COORD_W'(z);
    return c;
  endfunction

  // Mostly cells inside the current coastal band, some right on its edges
  // and a few anywhere; the neighbours are flat, gently or steeply sloped.
  function automatic sample_t random_cell(input longint gscale);
    longint h, sea, t, span;
    int     mode;
    sea = regs.sea_level;
    t   = regs.band_threshold;
    case ($urandom_range(9))
      0:       h = spread(HALF_RANGE);
      1:       h = sea + t + $urandom_range(2);
      2:       h = sea - t - $urandom_range(2);
      default: h = sea + spread(t);
    endcase
    mode = $urandom_range(5);
    span = (mode == 0) ? 0 : (mode <= 2) ? 16 : (mode <= 4) ? gscale : HALF_RANGE;
    return make_cell(h, h + spread(span), h + spread(span), h + spread(span),
                     h + spread(span), random_coord(), random_coord());
  endfunction

  task automatic run_cells(input int n, input longint gscale);
    repeat (n) cell_q.push_back(random_cell(gscale));
  endtask

  // Waits until every queued cell has gone in and every predicted word has
  // come out, then lets the pipeline run empty of bubbles.
  task automatic settle();
    do @(negedge clk); while (cell_q.size() != 0 || s_tvalid || delta_q.size() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  // One register write; bits above the register's width carry random junk.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input int width);
    logic [CFG_DATA_W-1:0] mask, word;
    mask = (CFG_DATA_W'(1) << width) - 1;
    word = (CFG_DATA_W'({$urandom, $urandom}) & ~mask) | (value & mask);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    case (idx)
      CFG_SEA_LEVEL:   regs.sea_level         = word[HEIGHT_W-1:0];
      CFG_BAND_THRESH: regs.band_threshold    = word[THRESH_W-1:0];
      CFG_GRAD_LIMIT:  regs.gradient_limit_sq = word;
      CFG_LAND_LIFT:   regs.land_lift         = word[HEIGHT_W-1:0];
      CFG_SEA_CUT:     regs.sea_cut           = word[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrites the whole register file once the block has gone quiet. Writes
  // to the unused indexes follow; the block must ignore them.
  task automatic apply_setting(input logic [HEIGHT_W-1:0] sea, input logic [THRESH_W-1:0] thr,
                               input logic [GLIM_W-1:0] glim, input logic [HEIGHT_W-1:0] lift,
                               input logic [HEIGHT_W-1:0] cut);
    settle();
    write_reg(CFG_SEA_LEVEL, sea, HEIGHT_W);
    write_reg(CFG_BAND_THRESH, thr, THRESH_W);
    write_reg(CFG_GRAD_LIMIT, glim, GLIM_W);
    write_reg(CFG_LAND_LIFT, lift, HEIGHT_W);
    write_reg(CFG_SEA_CUT, cut, HEIGHT_W);
    for (int i = CFG_LAST + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'({$urandom, $urandom}), GLIM_W);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    longint gscale, thr, lift, cut;
    regs.sea_level         = '0;
    regs.band_threshold    = 23'd256;
    regs.gradient_limit_sq = '0;
    regs.land_lift         = '0;
    regs.sea_cut           = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults: lift and cut are zero, so in-band cells give nothing.
    run_cells(4, 50);

    // Directed cells around a 1 m band at sea level.
    apply_setting('0, 23'd256, '0, 24'h001000, 24'h000800);
    cell_q.push_back(make_cell(0, 0, 0, 0, 0, 0, 0));            // at sea level, sea side
    cell_q.push_back(make_cell(256, 0, 0, 0, 0, 1, 1));          // top of band, zero weight
    cell_q.push_back(make_cell(-256, 0, 0, 0, 0, 2, 2));         // bottom of band
    cell_q.push_back(make_cell(257, 0, 0, 0, 0, 3, 3));          // just above the band
    cell_q.push_back(make_cell(-257, 0, 0, 0, 0, 4, 4));         // just below the band
    cell_q.push_back(make_cell(1, 5, -5, 7, -7, 63, 64));
    cell_q.push_back(make_cell(-128, 0, 9, 0, 9, 64, 63));
    cell_q.push_back(make_cell(128, 3, 3, 3, 3, -1, -64));
    cell_q.push_back(make_cell(100, 1, 2, 3, 4, -65, -8388608));
    cell_q.push_back(make_cell(-100, 4, 3, 2, 1, 8388607, 8388607));
    cell_q.push_back(make_cell(-8388608, 8388607, -8388608, 8388607, -8388608, 0, 0));
    cell_q.push_back(make_cell(8388607, -8388608, 8388607, -8388608, 8388607, 0, 0));
    cell_q.push_back(make_cell(10, -8388608, 8388607, 8388607, -8388608, -8388608, 0));
    cell_q.push_back(make_cell(255, 0, 0, 0, 0, 64, -1));        // tiny weight rounds to zero
    cell_q.push_back(make_cell(-1, 0, 0, 0, 0, -63, -129));

    // Widest band from the bottom of the range; the sea cut of -2^23 has to
    // saturate when negated.
    apply_setting(24'h800000, 23'h7FFFFF, '0, 24'h7FFFFF, 24'h800000);
    cell_q.push_back(make_cell(-8388608, 0, 0, 0, 0, 0, 0));
    cell_q.push_back(make_cell(-8388607, 0, 0, 0, 0, -64, 64));
    cell_q.push_back(make_cell(-1, 0, 0, 0, 0, 127, -127));
    run_cells(100, 4000);

    // Narrowest useful band at the top of the range, extreme lift and cut.
    apply_setting(24'h7FFFFF, 23'd2, 49'd100, 24'h800000, 24'h7FFFFF);
    run_cells(100, 20);

    // Band switched off: nothing may come out.
    apply_setting(HEIGHT_W'($urandom), '0, '0, 24'h001000, 24'h001000);
    run_cells(20, 100);

    // Gradient limit equal to the steepest possible slope: only that passes.
    apply_setting('0, 23'h7FFFFF, GLIM_W'(GRAD_EDGE), 24'd1000, 24'd1000);
    cell_q.push_back(make_cell(100, -8388608, 8388607, -8388608, 8388607, 5, 5));
    cell_q.push_back(make_cell(100, -8388608, 8388606, -8388608, 8388607, 6, 6));
    cell_q.push_back(make_cell(-100, 8388607, -8388608, 8388607, -8388608, 7, 7));
    run_cells(30, HALF_RANGE);

    // Gradient limit at its maximum: no slope is steep enough.
    apply_setting('0, 23'h7FFFFF, '1, 24'd1000, 24'd1000);
    cell_q.push_back(make_cell(0, -8388608, 8388607, -8388608, 8388607, 5, 5));
    run_cells(10, HALF_RANGE);

    // Random settings. The second one carries large lift and cut so that the
    // long receiver hold-off backs the pipeline up; the third runs with no
    // idling at all.
    for (int k = 0; k < 5; k++) begin
      gscale = pick_scale();
      thr    = (k == 1) ? 4096 : pick_scale();
      if ($urandom_range(3) != 0 || k == 1) begin
        lift = (k == 1) ? 24'h400000 : $urandom;
        cut  = (k == 1) ? 24'h300000 : $urandom;
      end else begin
        lift = spread(300);
        cut  = spread(300);
      end
      apply_setting(HEIGHT_W'($urandom), THRESH_W'(thr),
                    GLIM_W'((gscale * gscale) >> $urandom_range(2)),
                    HEIGHT_W'(lift), HEIGHT_W'(cut));
      if (k == 1) hold_request = 1'b1;
      steady = (k == 2);
      run_cells(85, gscale);
    end

    settle();
    if (delta_q.size() != 0)
      note_mismatch($sformatf("%0d expected words never arrived", delta_q.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a run that hangs ends here as a failure.
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
